// ===== hw/rtl/rps_pkg.sv =====
package rps_pkg;

  localparam int PIXEL_BITS    = 16;
  localparam int COUNT_BITS    = 32;
  localparam int HIST_BINS     = 256;
  localparam int BIN_BITS      = $clog2(HIST_BINS);
  localparam int DIV_STEP_BITS = $clog2(BIN_BITS);
  localparam int SUM_BITS      = 48;
  localparam int SQ_BITS       = 64;
  localparam int CFG_BITS      = 16;
  localparam int SPAN_BITS     = CFG_BITS + 1;

  localparam logic [1:0] ACT_ACCUM = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam logic REG_SAT_LEVEL  = 1'b0;
  localparam logic REG_DARK_LEVEL = 1'b1;

  localparam logic [CFG_BITS-1:0] SAT_LEVEL_RESET  = 16'd4095;
  localparam logic [CFG_BITS-1:0] DARK_LEVEL_RESET = 16'd0;

  typedef enum logic [1:0] {
    OP_ACCUM,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_BUMP,
    ST_SEL,
    ST_FETCH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] pixel;
    logic [7:0]  bin_index;
  } req_t;

  typedef struct packed {
    op_t                   op;
    logic [PIXEL_BITS-1:0] pixel;
    logic [BIN_BITS-1:0]   bin_index;
  } cmd_t;

  typedef struct packed {
    logic [31:0] pixel_count;
    logic [15:0] minimum;
    logic [15:0] maximum;
    logic [47:0] pixel_sum;
    logic [63:0] square_sum;
    logic [31:0] sat_count;
    logic [31:0] dark_count;
    logic [31:0] bin_count;
  } res_t;

endpackage

// ===== hw/rtl/raw_pixel_statistics.sv =====
// Raw pixel statistics.
// Requests enter through a queue port: drive req and push, a request is taken
// at a clock edge with push high and full low. A two-entry request queue lets
// the source run ahead while the statistics engine works.
// Actions: accumulate a pixel, read a histogram bin, clear all statistics.
// Every request gives one result with the running statistics and the count
// of bin req.bin_index; it waits on res while empty is low and is taken at an
// edge with pop high. One result is held; while it is not taken the engine
// stalls before delivering the next, and the request queue fills and raises full.
// Steps: a clear delivers; a read fetches bin req.bin_index and delivers; an
// accumulate runs the 8-step bin divider if sat_level >= 256 and the pixel is
// below sat_level + 1, then reads and updates its bin, fetches bin req.bin_index
// and delivers. The next request is taken right after delivering, paced by the
// single histogram memory port and the divider. sat_level and dark_level are
// written on wr_en/wr_index/wr_data; the user must write them only while idle,
// the block does not enforce it. Reset (rst, synchronous) sets sat_level 4095,
// dark_level 0, and clears all statistics, the histogram and the queue at once.
module raw_pixel_statistics (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  rps_pkg::req_t                req,
  output logic                         full,
  output logic                         empty,
  input  logic                         pop,
  output rps_pkg::res_t                res,
  input  logic                         wr_en,
  input  logic                         wr_index,
  input  logic [rps_pkg::CFG_BITS-1:0] wr_data
);
  import rps_pkg::*;

  logic [CFG_BITS-1:0] sat_level;
  logic [CFG_BITS-1:0] dark_level;
  logic                q_valid;
  cmd_t                q_cmd;
  logic                q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_level  <= SAT_LEVEL_RESET;
      dark_level <= DARK_LEVEL_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_SAT_LEVEL:  sat_level <= wr_data;
        REG_DARK_LEVEL: dark_level <= wr_data;
        default: ;
      endcase
    end
  end

  rps_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .req     (req),
    .full    (full),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  rps_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .sat_level  (sat_level),
    .dark_level (dark_level),
    .empty      (empty),
    .pop        (pop),
    .res        (res)
  );

endmodule

// ===== hw/rtl/rps_front.sv =====
module rps_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rps_pkg::req_t req,
  output logic          full,
  output logic          q_valid,
  output rps_pkg::cmd_t q_cmd,
  input  logic          q_pop
);
  import rps_pkg::*;

  cmd_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  cmd_t       cmd_in;
  logic       wr;

  always_comb begin
    cmd_in.pixel     = req.pixel[PIXEL_BITS-1:0];
    cmd_in.bin_index = req.bin_index[BIN_BITS-1:0];
    case (req.action)
      ACT_ACCUM: cmd_in.op = OP_ACCUM;
      ACT_CLEAR: cmd_in.op = OP_CLEAR;
      default:   cmd_in.op = OP_READ;
    endcase
  end

  assign full    = (fill == 2'd2);
  assign wr      = push && !full;
  assign q_valid = (fill != 2'd0);
  assign q_cmd   = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      fill <= fill + {1'b0, wr} - {1'b0, q_pop};
    end
  end

endmodule

// ===== hw/rtl/rps_div.sv =====
module rps_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rps_pkg::PIXEL_BITS-1:0] dividend,
  input  logic [rps_pkg::SPAN_BITS-1:0]  divisor,
  output logic                           done,
  output logic [rps_pkg::BIN_BITS-1:0]   quo
);
  import rps_pkg::*;

  // dividend < divisor, so (dividend * HIST_BINS) / divisor fits in BIN_BITS
  logic [SPAN_BITS-1:0]     rem;
  logic [SPAN_BITS-1:0]     dvs;
  logic [SPAN_BITS:0]       trial;
  logic [DIV_STEP_BITS-1:0] step;
  logic                     busy;
  logic                     fits;

  assign trial = {rem, 1'b0};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= SPAN_BITS'(dividend);
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? SPAN_BITS'(trial - {1'b0, dvs}) : trial[SPAN_BITS-1:0];
      quo <= {quo[BIN_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == DIV_STEP_BITS'(BIN_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/rps_back.sv =====
module rps_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  rps_pkg::cmd_t                q_cmd,
  output logic                         q_pop,
  input  logic [rps_pkg::CFG_BITS-1:0] sat_level,
  input  logic [rps_pkg::CFG_BITS-1:0] dark_level,
  output logic                         empty,
  input  logic                         pop,
  output rps_pkg::res_t                res
);
  import rps_pkg::*;

  state_t state;
  state_t state_next;

  logic [COUNT_BITS-1:0] count_reg;
  logic [PIXEL_BITS-1:0] min_reg;
  logic [PIXEL_BITS-1:0] max_reg;
  logic [SUM_BITS-1:0]   sum_reg;
  logic [SQ_BITS-1:0]    square_reg;
  logic [COUNT_BITS-1:0] sat_reg;
  logic [COUNT_BITS-1:0] black_reg;

  logic [2*PIXEL_BITS-1:0] sq;
  logic [PIXEL_BITS-1:0]   pix;
  logic [BIN_BITS-1:0]     sel;
  logic [BIN_BITS-1:0]     bin;
  logic [COUNT_BITS-1:0]   bin_val;
  logic                    out_valid;
  res_t                    out_reg;

  logic [COUNT_BITS-1:0] hist [HIST_BINS];
  logic [HIST_BINS-1:0]  hvalid;
  logic [COUNT_BITS-1:0] rdata;
  logic                  rvalid;
  logic [COUNT_BITS-1:0] bumped;

  logic [SPAN_BITS-1:0] span;
  logic                 wide;
  logic                 use_div;
  logic [BIN_BITS-1:0]  direct_bin;
  logic                 div_start;
  logic                 div_done;
  logic [BIN_BITS-1:0]  div_quo;
  logic                 rd_en;
  logic [BIN_BITS-1:0]  rd_addr;
  logic                 load_out;
  logic                 do_clear;
  logic                 do_bump;

  assign span    = SPAN_BITS'(sat_level) + 1'b1;
  assign wide    = (span > SPAN_BITS'(HIST_BINS));
  assign use_div = wide && (SPAN_BITS'(q_cmd.pixel) < span);

  always_comb begin
    if (wide) begin
      direct_bin = '1;
    end else if (q_cmd.pixel > PIXEL_BITS'(HIST_BINS - 1)) begin
      direct_bin = '1;
    end else begin
      direct_bin = q_cmd.pixel[BIN_BITS-1:0];
    end
  end

  assign bumped = (rvalid ? rdata : '0) + 1'b1;

  rps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (q_cmd.pixel),
    .divisor  (span),
    .done     (div_done),
    .quo      (div_quo)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            OP_ACCUM: state_next = use_div ? ST_DIV : ST_BUMP;
            OP_CLEAR: state_next = ST_EMIT;
            default:  state_next = ST_FETCH;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_BUMP;
        end
      end
      ST_BUMP:  state_next = ST_SEL;
      ST_SEL:   state_next = ST_FETCH;
      ST_FETCH: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid || pop) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = sel;
    load_out  = 1'b0;
    do_clear  = 1'b0;
    do_bump   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            OP_ACCUM: begin
              div_start = use_div;
              rd_en     = !use_div;
              rd_addr   = direct_bin;
            end
            OP_CLEAR: do_clear = 1'b1;
            default: begin
              rd_en   = 1'b1;
              rd_addr = q_cmd.bin_index;
            end
          endcase
        end
      end
      ST_DIV: begin
        rd_en   = div_done;
        rd_addr = div_quo;
      end
      ST_BUMP: do_bump = 1'b1;
      ST_SEL:  rd_en = 1'b1;
      ST_EMIT: load_out = !out_valid || pop;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pix <= q_cmd.pixel;
      sel <= q_cmd.bin_index;
      sq  <= q_cmd.pixel * q_cmd.pixel;
      bin <= direct_bin;
    end else if (state == ST_DIV && div_done) begin
      bin <= div_quo;
    end
    if (q_pop && q_cmd.op == OP_CLEAR) begin
      bin_val <= '0;
    end else if (state == ST_FETCH) begin
      bin_val <= rvalid ? rdata : '0;
    end
  end

  // histogram; a bin without its valid bit reads as zero
  always_ff @(posedge clk) begin
    if (do_bump) begin
      hist[bin] <= bumped;
    end
    if (rd_en) begin
      rdata  <= hist[rd_addr];
      rvalid <= hvalid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      hvalid <= '0;
    end else if (do_bump) begin
      hvalid[bin] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg  <= '0;
      min_reg    <= SAT_LEVEL_RESET;
      max_reg    <= '0;
      sum_reg    <= '0;
      square_reg <= '0;
      sat_reg    <= '0;
      black_reg  <= '0;
    end else if (do_clear) begin
      count_reg  <= '0;
      min_reg    <= sat_level;
      max_reg    <= '0;
      sum_reg    <= '0;
      square_reg <= '0;
      sat_reg    <= '0;
      black_reg  <= '0;
    end else if (do_bump) begin
      count_reg  <= count_reg + 1'b1;
      sum_reg    <= sum_reg + SUM_BITS'(pix);
      square_reg <= square_reg + SQ_BITS'(sq);
      if (pix < min_reg) begin
        min_reg <= pix;
      end
      if (pix > max_reg) begin
        max_reg <= pix;
      end
      if (pix >= sat_level) begin
        sat_reg <= sat_reg + 1'b1;
      end
      if (pix <= dark_level) begin
        black_reg <= black_reg + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_reg.pixel_count <= count_reg;
      out_reg.minimum     <= min_reg;
      out_reg.maximum     <= max_reg;
      out_reg.pixel_sum   <= sum_reg;
      out_reg.square_sum  <= square_reg;
      out_reg.sat_count   <= sat_reg;
      out_reg.dark_count  <= black_reg;
      out_reg.bin_count   <= bin_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign empty = !out_valid;
  assign res   = out_reg;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == ST_IDLE) else $error("request taken outside idle");
  a_clear_min: assert property (@(posedge clk) disable iff (rst)
    do_clear |=> (min_reg == $past(sat_level)) && (count_reg == '0) && (hvalid == '0))
    else $error("clear did not reset statistics");
  a_bump_valid: assert property (@(posedge clk) disable iff (rst)
    do_bump |=> hvalid[$past(bin)]) else $error("bumped bin not marked valid");
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV) else $error("divider finished outside divide");
`endif

endmodule

// ===== test/rps_checker.sv =====
`timescale 1ns / 1ps
module rps_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic           full,
  input  rps_pkg::req_t  req,
  input  logic           empty,
  input  logic           pop,
  input  rps_pkg::res_t  res,
  input  logic           wr_en,
  input  logic           wr_index,
  input  logic [15:0]    wr_data,
  output int             errors,
  output int             pending
);
  import rps_pkg::*;

  logic [15:0] sat_level, dark_level;
  logic [31:0] count, sat, black;
  logic [15:0] min_pix, max_pix;
  logic [47:0] sum;
  logic [63:0] sq;
  logic [31:0] hist [HIST_BINS];
  res_t        stats_q [$];

  function automatic logic [7:0] bin_of(logic [15:0] v);
    logic [16:0] span;
    logic [31:0] b;
    span = {1'b0, sat_level} + 17'd1;
    if (span > 17'd256) b = ({16'd0, v} * 32'd256) / {15'd0, span};
    else b = {16'd0, v};
    if (b > 32'd255) b = 32'd255;
    return b[7:0];
  endfunction

  task automatic clear_stats();
    count = '0; sat = '0; black = '0; max_pix = '0; sum = '0; sq = '0;
    min_pix = sat_level;
    for (int i = 0; i < HIST_BINS; i++) hist[i] = '0;
  endtask

  assign pending = stats_q.size();

  always @(posedge clk) begin
    res_t   r, e;
    logic [7:0] b;
    if (rst) begin
      sat_level = SAT_LEVEL_RESET;
      dark_level = DARK_LEVEL_RESET;
      clear_stats();
      stats_q.delete();
      errors = 0;
    end else begin
      if (wr_en) begin
        if (wr_index == REG_SAT_LEVEL) sat_level = wr_data;
        else dark_level = wr_data;
      end
      if (push && !full) begin
        if (req.action == ACT_ACCUM) begin
          count++; sum += req.pixel;
          sq += 64'(req.pixel) * 64'(req.pixel);
          if (req.pixel < min_pix) min_pix = req.pixel;
          if (req.pixel > max_pix) max_pix = req.pixel;
          if (req.pixel >= sat_level) sat++;
          if (req.pixel <= dark_level) black++;
          b = bin_of(req.pixel);
          hist[b]++;
        end else if (req.action == ACT_CLEAR) begin
          clear_stats();
        end
        r = '{count, min_pix, max_pix, sum, sq, sat, black, hist[req.bin_index]};
        stats_q.push_back(r);
      end
      if (pop && !empty) begin
        if (stats_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, res);
          errors++;
        end else begin
          e = stats_q.pop_front();
          if (res !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, res);
            errors++;
          end
        end
      end
    end
  end
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import rps_pkg::*;

  logic        clk, rst, push, full, empty, pop, wr_en, wr_index;
  logic [15:0] wr_data;
  req_t        req;
  res_t        res;
  int          errors, pending;
  bit          hold_off, drain_done;

  raw_pixel_statistics dut (.*);
  rps_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send(logic [1:0] a, logic [15:0] p, logic [7:0] b);
    push <= 1'b1;
    req <= '{a, p, b};
    @(posedge clk);
    while (full) @(posedge clk);
    if ($urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 2))
        @(posedge clk);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_reg(logic idx, logic [15:0] v);
    wr_en <= 1'b1; wr_index <= idx; wr_data <= v;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  function automatic logic [15:0] rand_pixel(logic [15:0] mv);
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return mv;
      3: return mv + 16'd1;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    logic [15:0] mv;
    int unsigned r;
    rst = 1; push = 0; wr_en = 0; wr_index = 0; wr_data = 0;
    req = '0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(ACT_READ, 16'd0, 8'd0);
    send(ACT_ACCUM, 16'h0000, 8'd0);
    send(ACT_ACCUM, 16'hFFFF, 8'd255);
    send(ACT_ACCUM, 16'd4095, 8'd255);
    send(ACT_ACCUM, 16'd4094, 8'd255);
    send(ACT_ACCUM, 16'd16, 8'd1);
    send(ACT_ACCUM, 16'd16, 8'd1);
    send(ACT_SPARE, 16'h1234, 8'd1);
    send(ACT_READ, 16'hAAAA, 8'hFF);
    send(ACT_CLEAR, 16'd0, 8'd255);
    send(ACT_ACCUM, 16'd100, 8'd1);
    drain();
    set_reg(REG_SAT_LEVEL, 16'd200);
    set_reg(REG_DARK_LEVEL, 16'd50);
    send(ACT_ACCUM, 16'd50, 8'd50);
    send(ACT_ACCUM, 16'd300, 8'd255);
    send(ACT_CLEAR, 16'd0, 8'd0);
    send(ACT_ACCUM, 16'd199, 8'd199);
    send(ACT_ACCUM, 16'd200, 8'd200);
    send(ACT_ACCUM, 16'd51, 8'd51);
    drain();
    set_reg(REG_SAT_LEVEL, 16'hFFFF);
    set_reg(REG_DARK_LEVEL, 16'hFFFF);
    send(ACT_CLEAR, 16'd0, 8'd0);
    send(ACT_ACCUM, 16'hFFFF, 8'd255);
    send(ACT_ACCUM, 16'h5555, 8'd85);
    drain();
    set_reg(REG_SAT_LEVEL, 16'd0);
    set_reg(REG_DARK_LEVEL, 16'd0);
    send(ACT_ACCUM, 16'd0, 8'd0);
    send(ACT_ACCUM, 16'd1, 8'd1);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: mv = 16'd4095;
        1: mv = 16'd255;
        2: mv = 16'd256;
        3: mv = 16'hFFFF;
        default: mv = 16'($urandom_range(0, 65535));
      endcase
      set_reg(REG_SAT_LEVEL, mv);
      set_reg(REG_DARK_LEVEL,
              $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 4000)));
      if (ph == 3) hold_off = 1;
      for (int i = 0; i < 100; i++) begin
        r = $urandom_range(0, 99);
        if (r < 75) send(ACT_ACCUM, rand_pixel(mv), 8'($urandom_range(0, 255)));
        else if (r < 92)
          send(ACT_READ, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        else if (r < 97)
          send(ACT_CLEAR, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        else send(ACT_SPARE, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      end
      drain();
    end
    if (errors == 0 && pending == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int stall;
    pop = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off && !drain_done) begin
        drain_done = 1;
        pop <= 1'b0;
        repeat (200) @(posedge clk);
      end
      stall = $urandom_range(0, 99);
      if (stall < 70) pop <= 1'b1;
      else begin
        pop <= 1'b0;
        repeat (stall > 96 ? $urandom_range(10, 40) : $urandom_range(0, 2)) @(posedge clk);
        pop <= 1'b1;
      end
    end
  end
endmodule
